// ----- rtl/rmmq_pkg.sv -----
// Shared types, constants and command codes for the range minimum/maximum query table.
`timescale 1ns / 1ps
package rmmq_pkg;

	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int COUNT_W = 11;
	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam int RESET_COUNT = 1024;

	localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_NOP   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_QERR  = 2'd3;

	typedef struct packed {
		logic                    op;
		logic [IDX_W-1:0]        element_index;
		logic signed [VAL_W-1:0] element_value;
		logic [IDX_W-1:0]        range_start;
		logic [IDX_W-1:0]        range_end;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] range_minimum;
		logic signed [VAL_W-1:0] range_maximum;
		logic                    range_error;
	} rsp_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [IDX_W-1:0]        element_index;
		logic signed [VAL_W-1:0] element_value;
		logic [IDX_W-1:0]        range_start;
		logic [IDX_W-1:0]        range_end;
	} cmd_t;

endpackage

// ----- rtl/rmmq_front.sv -----
// Front end: classifies incoming items and holds them in a two-entry queue.
`timescale 1ns / 1ps
module rmmq_front #(
	parameter int MAX_ELEMENTS = rmmq_pkg::DEF_MAX_ELEMENTS,
	parameter int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    count,
	input  logic                req_valid,
	output logic                req_ready,
	input  rmmq_pkg::req_t      req,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output rmmq_pkg::cmd_t      cmd
);
	import rmmq_pkg::*;

	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       cls;
	logic       push;
	logic       pop;
	logic [CMP_W-1:0] cnt_x;

	assign cnt_x = CMP_W'(count);

	always_comb begin
		cls.element_index = req.element_index;
		cls.element_value = req.element_value;
		cls.range_start   = req.range_start;
		cls.range_end     = req.range_end;
		if (req.op == OP_WRITE) begin
			// Writes beyond the element count are dropped but still answered.
			cls.kind = (CMP_W'(req.element_index) < cnt_x) ? CMD_WRITE : CMD_NOP;
		end else begin
			cls.kind = ((req.range_start > req.range_end) || (CMP_W'(req.range_end) >= cnt_x))
				? CMD_QERR : CMD_QUERY;
		end
	end

	assign req_ready = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= cls;
	end

endmodule

// ----- rtl/rmmq_back.sv -----
// Back end: walks the segment tree in node memory to carry out writes and queries.
`timescale 1ns / 1ps
module rmmq_back #(
	parameter int MAX_ELEMENTS = rmmq_pkg::DEF_MAX_ELEMENTS,
	parameter int CNT_W = $clog2(MAX_ELEMENTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] count,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  rmmq_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output rmmq_pkg::rsp_t   res
);
	import rmmq_pkg::*;

	localparam int IW    = $clog2(MAX_ELEMENTS);
	localparam int NODES = 4 * MAX_ELEMENTS;
	localparam int NAW   = $clog2(NODES);
	localparam int SD    = IW + 2;
	localparam int SAW   = $clog2(SD);
	localparam int SPW   = $clog2(SD + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DESC   = 3'd1;
	localparam logic [2:0] ST_UP_RD  = 3'd2;
	localparam logic [2:0] ST_UP_WR  = 3'd3;
	localparam logic [2:0] ST_Q_EVAL = 3'd4;
	localparam logic [2:0] ST_Q_ACC  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic signed [VAL_W-1:0] min_mem [NODES];
	logic signed [VAL_W-1:0] max_mem [NODES];
	logic [NAW-1:0] stk_node [SD];
	logic [IW-1:0]  stk_s [SD];
	logic [IW-1:0]  stk_e [SD];

	logic [2:0]              st_q;
	logic [1:0]              kind_q;
	logic [NAW-1:0]          node_q;
	logic [IW-1:0]           s_q, e_q, qs_q, qe_q;
	logic signed [VAL_W-1:0] val_q, acc_min_q, acc_max_q;
	logic [SPW-1:0]          sp_q;
	logic signed [VAL_W-1:0] rd_min_q, rd_max_q;
	// Position of the element being written, held for the descent.
	logic [IDX_W-1:0]        val_index_q;

	logic [IW-1:0]           mid;
	logic [NAW-1:0]          left, right, sibling, parent, raddr;
	logic [SPW-1:0]          sp_dec;
	logic                    disjoint, contained;
	logic                    mem_we;
	logic [NAW-1:0]          waddr;
	logic signed [VAL_W-1:0] wmin, wmax, pmin, pmax;
	logic                    push;

	assign mid       = s_q + ((e_q - s_q) >> 1);
	assign left      = (node_q << 1) + NAW'(1);
	assign right     = (node_q << 1) + NAW'(2);
	assign sibling   = node_q[0] ? node_q + NAW'(1) : node_q - NAW'(1);
	assign parent    = (node_q - NAW'(1)) >> 1;
	assign sp_dec    = sp_q - SPW'(1);
	assign disjoint  = (e_q < qs_q) || (s_q > qe_q);
	assign contained = (qs_q <= s_q) && (qe_q >= e_q);
	assign pmin      = (acc_min_q < rd_min_q) ? acc_min_q : rd_min_q;
	assign pmax      = (acc_max_q > rd_max_q) ? acc_max_q : rd_max_q;
	assign raddr     = (st_q == ST_UP_RD) ? sibling : node_q;
	assign push      = (st_q == ST_Q_EVAL) && !disjoint && !contained;

	always_comb begin
		mem_we = 1'b0;
		waddr  = node_q;
		wmin   = val_q;
		wmax   = val_q;
		if ((st_q == ST_DESC) && (s_q == e_q)) begin
			mem_we = 1'b1;
		end else if (st_q == ST_UP_WR) begin
			mem_we = 1'b1;
			waddr  = parent;
			wmin   = pmin;
			wmax   = pmax;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			min_mem[waddr] <= wmin;
			max_mem[waddr] <= wmax;
		end
		rd_min_q <= min_mem[raddr];
		rd_max_q <= max_mem[raddr];
	end

	// The right half waits on the stack while the left half is explored.
	always_ff @(posedge clk) begin
		if (push) begin
			stk_node[sp_q[SAW-1:0]] <= right;
			stk_s[sp_q[SAW-1:0]]    <= mid + IW'(1);
			stk_e[sp_q[SAW-1:0]]    <= e_q;
		end
	end

	assign cmd_ready = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_DONE);
	assign res.range_minimum = (kind_q == CMD_WRITE) ? '0 : acc_min_q;
	assign res.range_maximum = (kind_q == CMD_WRITE) ? '0 : acc_max_q;
	assign res.range_error   = (kind_q == CMD_QERR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			kind_q    <= CMD_WRITE;
			sp_q      <= '0;
			node_q    <= '0;
			s_q       <= '0;
			e_q       <= '0;
			qs_q      <= '0;
			qe_q      <= '0;
			val_q     <= '0;
			acc_min_q <= '0;
			acc_max_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						node_q    <= '0;
						s_q       <= '0;
						e_q       <= IW'(count - CNT_W'(1));
						qs_q      <= IW'(cmd.range_start);
						qe_q      <= IW'(cmd.range_end);
						val_q     <= cmd.element_value;
						sp_q      <= '0;
						acc_min_q <= INT_MAX;
						acc_max_q <= INT_MIN;
						unique case (cmd.kind)
							CMD_WRITE: begin
								kind_q <= CMD_WRITE;
								st_q   <= ST_DESC;
							end
							CMD_QUERY: begin
								kind_q <= CMD_QUERY;
								st_q   <= ST_Q_EVAL;
							end
							CMD_QERR: begin
								kind_q <= CMD_QERR;
								st_q   <= ST_DONE;
							end
							default: begin
								kind_q <= CMD_WRITE;
								st_q   <= ST_DONE;
							end
						endcase
					end
				end
				ST_DESC: begin
					if (s_q == e_q) begin
						acc_min_q <= val_q;
						acc_max_q <= val_q;
						st_q      <= (node_q == '0) ? ST_DONE : ST_UP_RD;
					end else if (IW'(val_index_q) <= mid) begin
						e_q    <= mid;
						node_q <= left;
					end else begin
						s_q    <= mid + IW'(1);
						node_q <= right;
					end
				end
				ST_UP_RD: begin
					st_q <= ST_UP_WR;
				end
				ST_UP_WR: begin
					acc_min_q <= pmin;
					acc_max_q <= pmax;
					node_q    <= parent;
					st_q      <= (parent == '0) ? ST_DONE : ST_UP_RD;
				end
				ST_Q_EVAL: begin
					if (disjoint) begin
						if (sp_q == '0) begin
							st_q <= ST_DONE;
						end else begin
							node_q <= stk_node[sp_dec[SAW-1:0]];
							s_q    <= stk_s[sp_dec[SAW-1:0]];
							e_q    <= stk_e[sp_dec[SAW-1:0]];
							sp_q   <= sp_dec;
						end
					end else if (contained) begin
						st_q <= ST_Q_ACC;
					end else begin
						node_q <= left;
						e_q    <= mid;
						sp_q   <= sp_q + SPW'(1);
					end
				end
				ST_Q_ACC: begin
					if (rd_min_q < acc_min_q) acc_min_q <= rd_min_q;
					if (rd_max_q > acc_max_q) acc_max_q <= rd_max_q;
					if (sp_q == '0) begin
						st_q <= ST_DONE;
					end else begin
						node_q <= stk_node[sp_dec[SAW-1:0]];
						s_q    <= stk_s[sp_dec[SAW-1:0]];
						e_q    <= stk_e[sp_dec[SAW-1:0]];
						sp_q   <= sp_dec;
						st_q   <= ST_Q_EVAL;
					end
				end
				ST_DONE: begin
					if (res_ready) st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) val_index_q <= cmd.element_index;
	end

endmodule

// ----- rtl/range_min_max_query_table.sv -----
// Top level of the range minimum/maximum query table over a segment tree.
// A write descends the tree in ST_DESC, one level per step, then climbs back up through
// ST_UP_RD and ST_UP_WR, as each ancestor needs one registered read of node memory.
// A query splits or skips each node in ST_Q_EVAL and reads each contained node in ST_Q_ACC,
// visiting about 4 * log2(element_count) nodes at most.
// One item is worked on at a time; a two-entry queue takes items while the back end is busy.
// Reset clears control state, not node memory; element_count is min(1024, MAX_ELEMENTS).
`timescale 1ns / 1ps
module range_min_max_query_table #(
	parameter int MAX_ELEMENTS = rmmq_pkg::DEF_MAX_ELEMENTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rmmq_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  rmmq_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output rmmq_pkg::rsp_t                rsp
);
	import rmmq_pkg::*;

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int RST_CNT = (MAX_ELEMENTS < RESET_COUNT) ? MAX_ELEMENTS : RESET_COUNT;

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] cfg_x;
	logic [CNT_W-1:0] cfg_clamped;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;
	logic             res_valid;
	logic             res_ready;
	rsp_t             res;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	assign cfg_ready = 1'b1;
	assign cfg_x     = CMP_W'(cfg_data);

	always_comb begin
		if (cfg_x == '0) begin
			cfg_clamped = CNT_W'(1);
		end else if (cfg_x > CMP_W'(MAX_ELEMENTS)) begin
			cfg_clamped = CNT_W'(MAX_ELEMENTS);
		end else begin
			cfg_clamped = CNT_W'(cfg_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(RST_CNT);
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_clamped;
		end
	end

	rmmq_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.CNT_W(CNT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.count(count_q),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd)
	);

	rmmq_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.CNT_W(CNT_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.count(count_q),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Output register: the back end hands over a result whenever the slot is free or its result is being taken.
	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) rsp_q <= res;
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_W'(MAX_ELEMENTS)))
		else $error("element count outside its range");

	a_error_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.range_error) |->
		((rsp.range_minimum == INT_MAX) && (rsp.range_maximum == INT_MIN)))
		else $error("error result without the empty-range values");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the range minimum/maximum query table.
`timescale 1ns / 1ps
module testbench;
	import rmmq_pkg::*;

	localparam int CYCLE_LIMIT = 800000;

	typedef struct {
		bit                 is_cfg;
		logic [COUNT_W-1:0] cfg;
		req_t               item;
		bit                 typed;
		rsp_t               answer;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	range_min_max_query_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Predictor state: the array as the tree should see it, and the count in use.
	logic signed [VAL_W-1:0] element_store [DEF_MAX_ELEMENTS];
	int unsigned tree_size;
	rsp_t pending_answers [$];
	int mismatch_count;
	int cycle_count;
	int burst_left;
	int stall_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	function automatic rsp_t predict_answer(input req_t r);
		rsp_t a;
		a.range_minimum = '0;
		a.range_maximum = '0;
		a.range_error = 1'b0;
		if (r.op == OP_WRITE) begin
			if (r.element_index < tree_size)
				element_store[r.element_index] = r.element_value;
		end else begin
			a.range_minimum = INT_MAX;
			a.range_maximum = INT_MIN;
			if (r.range_start > r.range_end || r.range_end >= tree_size) begin
				a.range_error = 1'b1;
			end else begin
				for (int i = r.range_start; i <= r.range_end; i++) begin
					if (element_store[i] < a.range_minimum)
						a.range_minimum = element_store[i];
					if (element_store[i] > a.range_maximum)
						a.range_maximum = element_store[i];
				end
			end
		end
		return a;
	endfunction

	// Receiver: checks each item against the oldest expectation and stalls on its own
	// pattern, with stretches of always-ready and one long hold-off on request.
	int hold_left;
	int mode_left;
	bit ready_mode;
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left = 0;
			mode_left = 0;
			ready_mode = 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("unexpected item", rsp.range_minimum, 32'h0);
				end else begin
					want = pending_answers.pop_front();
					if (rsp.range_minimum !== want.range_minimum)
						report_mismatch("range_minimum", rsp.range_minimum,
							want.range_minimum);
					if (rsp.range_maximum !== want.range_maximum)
						report_mismatch("range_maximum", rsp.range_maximum,
							want.range_maximum);
					if (rsp.range_error !== want.range_error)
						report_mismatch("range_error", 32'(rsp.range_error),
							32'(want.range_error));
				end
			end
			if (stall_hold_req > 0) begin
				hold_left = stall_hold_req;
				stall_hold_req = 0;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(50, 300);
				ready_mode = $urandom_range(0, 2) == 0;
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ready_mode ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Offers one item; valid stays high into the next call unless a gap starts.
	task automatic send_item(input req_t r, input bit typed, input rsp_t answer);
		rsp_t predicted;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		predicted = predict_answer(r);
		pending_answers.push_back(typed ? answer : predicted);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		burst_left = 0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (value == 0)
			tree_size = 1;
		else if (value > DEF_MAX_ELEMENTS)
			tree_size = DEF_MAX_ELEMENTS;
		else
			tree_size = value;
	endtask

	function automatic req_t make_write(input int idx, input logic [31:0] val);
		req_t r;
		r.op = OP_WRITE;
		r.element_index = IDX_W'(idx);
		r.element_value = val;
		r.range_start = IDX_W'($urandom);
		r.range_end = IDX_W'($urandom);
		return r;
	endfunction

	function automatic req_t make_query(input int qs, input int qe);
		req_t r;
		r.op = OP_QUERY;
		r.element_index = IDX_W'($urandom);
		r.element_value = $urandom;
		r.range_start = IDX_W'(qs);
		r.range_end = IDX_W'(qe);
		return r;
	endfunction

	function automatic rsp_t make_answer(input logic [31:0] mn, input logic [31:0] mx,
			input logic err);
		rsp_t a;
		a.range_minimum = mn;
		a.range_maximum = mx;
		a.range_error = err;
		return a;
	endfunction

	step_row_t steps [$];

	task automatic add_row(input bit is_cfg, input logic [COUNT_W-1:0] cfg, input req_t item,
			input bit typed, input rsp_t answer);
		step_row_t s;
		s.is_cfg = is_cfg;
		s.cfg = cfg;
		s.item = item;
		s.typed = typed;
		s.answer = answer;
		steps.push_back(s);
	endtask

	initial begin
		int phase_counts [$];
		int qs;
		int qe;
		int pick;
		rsp_t none;
		rsp_t bad;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		stall_hold_req = 0;
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 0;
		tree_size = RESET_COUNT;
		for (int i = 0; i < DEF_MAX_ELEMENTS; i++) element_store[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		none = make_answer(32'h0, 32'h0, 1'b0);
		bad = make_answer(INT_MAX, INT_MIN, 1'b1);
		// After reset only writes and invalid queries, since no node has been built yet.
		add_row(0, 0, make_write(0, INT_MIN), 1, none);
		add_row(0, 0, make_write(1023, INT_MAX), 1, none);
		add_row(0, 0, make_query(1023, 0), 1, bad);
		add_row(0, 0, make_query(1, 0), 1, bad);
		// A count of zero is taken as one element.
		add_row(1, 0, '0, 0, none);
		add_row(0, 0, make_write(0, INT_MIN), 1, none);
		add_row(0, 0, make_query(0, 0), 1, make_answer(INT_MIN, INT_MIN, 1'b0));
		add_row(0, 0, make_write(0, INT_MAX), 1, none);
		add_row(0, 0, make_query(0, 0), 1, make_answer(INT_MAX, INT_MAX, 1'b0));
		add_row(0, 0, make_query(0, 1), 1, bad);
		add_row(0, 0, make_query(0, 1023), 1, bad);
		// A write beyond the count is dropped but still answers.
		add_row(0, 0, make_write(1023, 32'h5A5A_0001), 1, none);
		add_row(0, 0, make_write(1, 32'h0000_0000), 1, none);
		add_row(0, 0, make_query(0, 0), 0, none);
		add_row(1, 2, '0, 0, none);
		add_row(0, 0, make_write(0, 32'hFFFF_FFFF), 1, none);
		add_row(0, 0, make_write(1, 32'h0000_0001), 1, none);
		add_row(0, 0, make_query(0, 1), 1, make_answer(32'hFFFF_FFFF, 32'h1, 1'b0));
		add_row(0, 0, make_query(1, 1), 0, none);
		add_row(0, 0, make_query(1, 0), 1, bad);
		add_row(0, 0, make_query(0, 2), 1, bad);

		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				write_count(steps[i].cfg);
			else
				send_item(steps[i].item, steps[i].typed, steps[i].answer);
		end

		// Each setting starts with an ascending build so every node is written before
		// any query reads it. A count above the limit is taken as the limit.
		phase_counts = '{3, 13, 37, 2047};
		foreach (phase_counts[p]) begin
			write_count(COUNT_W'(phase_counts[p]));
			for (int i = 0; i < tree_size; i++)
				send_item(make_write(i, $urandom), 0, none);
			if (phase_counts[p] == 37)
				stall_hold_req = 400;
			for (int n = 0; n < 20; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					qs = $urandom_range(0, tree_size - 1);
					qe = $urandom_range(0, 3) == 0 ? $urandom_range(qs, tree_size - 1) :
						((qs + $urandom_range(0, 8) < tree_size) ?
						qs + $urandom_range(0, 8) : tree_size - 1);
					send_item(make_query(qs, qe), 0, none);
				end else if (pick < 85) begin
					send_item(make_write($urandom_range(0, tree_size - 1), $urandom), 0, none);
				end else if (pick < 93) begin
					qs = $urandom_range(1, 1023);
					send_item(make_query(qs, $urandom_range(0, qs - 1)), 0, none);
				end else if (tree_size < DEF_MAX_ELEMENTS) begin
					if (pick < 97)
						send_item(make_query($urandom_range(0, 1023),
							$urandom_range(tree_size, 1023)), 0, none);
					else
						send_item(make_write($urandom_range(tree_size, 1023), $urandom),
							0, none);
				end else begin
					send_item(make_query($urandom_range(0, 1023), $urandom_range(0, 1023)),
						0, none);
				end
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
